FILE: rtl/core/wialu_pkg.sv
// ----------------------------------------------------------------------------
// Wide integer ALU package
// Operation codes, sequencer states and fixed widths of the 128-bit ALU.
// ----------------------------------------------------------------------------
package wialu_pkg;

  localparam int unsigned WordW  = 128;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned TopBit = 127;
  localparam int unsigned CntW   = 7;
  localparam int unsigned AmtW   = 8;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_AND = 4'd4,
    OP_OR  = 4'd5,
    OP_XOR = 4'd6,
    OP_NOT = 4'd7,
    OP_SHL = 4'd8,
    OP_SHR = 4'd9,
    OP_ROL = 4'd10,
    OP_ROR = 4'd11,
    OP_CMP = 4'd12
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_NEG_A,
    ST_NEG_B,
    ST_DIV,
    ST_NEG_Q,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

FILE: rtl/core/wide_integer_alu_128.sv
// ----------------------------------------------------------------------------
// Wide integer ALU, 128 bits
// One item carries an operation and two 128-bit operands split into 64-bit
// halves; the block returns one item with the wrapped result and four flags.
// Both channels use valid and stall. An item is taken when in_valid_i is
// high and in_stall_o is low; in_stall_o stays high while an item is being
// worked on. The result item sits in an output register until the receiver
// lowers out_stall_i, and a new input item may be taken meanwhile.
// Add, subtract, compare, multiply and the division steps go through one
// shared 128-bit adder under a small sequencer; logic, shift and rotate
// do not use it. Add, subtract, logic, shift, rotate and compare go from
// the execute step straight to the done step. Multiply is shift and add,
// one multiplier bit per cycle. Division negates the operands, runs a
// restoring divider one quotient bit per cycle and fixes the sign;
// division by zero goes straight to the done step. The block returns to
// idle for the next item once the result enters the output register.
// A stalled receiver holds the last step until the output register is free.
// Reset clears the sequencer and the output valid; no item is pending.
// ----------------------------------------------------------------------------
module wide_integer_alu_128
  import wialu_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [3:0]       operation_i,
  input  logic [HalfW-1:0] a_high_i,
  input  logic [HalfW-1:0] a_low_i,
  input  logic [HalfW-1:0] b_high_i,
  input  logic [HalfW-1:0] b_low_i,
  input  logic [AmtW-1:0]  amount_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [HalfW-1:0] result_high_o,
  output logic [HalfW-1:0] result_low_o,
  output logic             less_o,
  output logic             equal_o,
  output logic             greater_o,
  output logic             error_o
);

  state_e state_q, state_d;
  logic [3:0] op_q, op_d;
  word_t a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [AmtW-1:0] amt_q, amt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic sign_q, sign_d;
  logic lt_q, lt_d, eq_q, eq_d, gt_q, gt_d, err_q, err_d;

  word_t res_q, res_d;
  logic out_valid_q, out_valid_d;
  logic out_lt_q, out_lt_d, out_eq_q, out_eq_d, out_gt_q, out_gt_d;
  logic out_err_q, out_err_d;

  word_t add_x, add_y;
  logic add_sub;
  logic [WordW:0] sum;
  logic [2*WordW-1:0] rot_l, rot_r;
  word_t div_rem;
  logic out_free, last_step;

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_free      = !out_valid_q || !out_stall_i;
  assign last_step     = (cnt_q == CntW'(TopBit));
  assign div_rem       = {acc_q[WordW-2:0], a_q[WordW-1]};
  assign rot_l         = {a_q, a_q} << amt_q[CntW-1:0];
  assign rot_r         = {a_q, a_q} >> amt_q[CntW-1:0];

  always_comb begin
    add_x   = a_q;
    add_y   = b_q;
    add_sub = 1'b1;
    case (state_q)
      ST_EXEC: begin
        add_sub = (op_q != OP_ADD);
        if (op_q == OP_CMP) begin
          add_x = {~a_q[WordW-1], a_q[WordW-2:0]};
          add_y = {~b_q[WordW-1], b_q[WordW-2:0]};
        end
      end
      ST_NEG_A: begin
        add_x = '0;
        add_y = a_q;
      end
      ST_NEG_B: begin
        add_x = '0;
        add_y = b_q;
      end
      ST_NEG_Q: begin
        add_x = '0;
        add_y = a_q;
      end
      ST_MUL: begin
        add_x   = acc_q;
        add_y   = a_q;
        add_sub = 1'b0;
      end
      ST_DIV: begin
        add_x = div_rem;
        add_y = b_q;
      end
      default: begin
        add_sub = 1'b1;
      end
    endcase
    sum = {1'b0, add_x} + {1'b0, add_y ^ {WordW{add_sub}}} + {{WordW{1'b0}}, add_sub};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_q == OP_MUL) begin
          state_d = ST_MUL;
        end else if (op_q == OP_DIV && b_q != '0) begin
          state_d = ST_NEG_A;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_NEG_A: state_d = ST_NEG_B;
      ST_NEG_B: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_NEG_Q;
        end
      end
      ST_NEG_Q: state_d = ST_DONE;
      ST_MUL: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    amt_d       = amt_q;
    cnt_d       = cnt_q;
    sign_d      = sign_q;
    lt_d        = lt_q;
    eq_d        = eq_q;
    gt_d        = gt_q;
    err_d       = err_q;
    res_d       = res_q;
    out_lt_d    = out_lt_q;
    out_eq_d    = out_eq_q;
    out_gt_d    = out_gt_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d   = operation_i;
          a_d    = {a_high_i, a_low_i};
          b_d    = {b_high_i, b_low_i};
          amt_d  = amount_i;
          sign_d = a_high_i[HalfW-1] ^ b_high_i[HalfW-1];
          cnt_d  = '0;
        end
      end
      ST_EXEC: begin
        acc_d = '0;
        lt_d  = 1'b0;
        eq_d  = 1'b0;
        gt_d  = 1'b0;
        err_d = 1'b0;
        case (op_q)
          OP_ADD, OP_SUB: acc_d = sum[WordW-1:0];
          OP_DIV: err_d = (b_q == '0);
          OP_AND: acc_d = a_q & b_q;
          OP_OR:  acc_d = a_q | b_q;
          OP_XOR: acc_d = a_q ^ b_q;
          OP_NOT: acc_d = ~a_q;
          OP_SHL: acc_d = amt_q[AmtW-1] ? '0 : a_q << amt_q[CntW-1:0];
          OP_SHR: acc_d = amt_q[AmtW-1] ? '0 : a_q >> amt_q[CntW-1:0];
          OP_ROL, OP_ROR: begin
            if (amt_q == '0 || amt_q[AmtW-1]) begin
              err_d = 1'b1;
              acc_d = a_q;
            end else if (op_q == OP_ROL) begin
              acc_d = rot_l[2*WordW-1:WordW];
            end else begin
              acc_d = rot_r[WordW-1:0];
            end
          end
          OP_CMP: begin
            eq_d = (a_q == b_q);
            lt_d = (a_q != b_q) && !sum[WordW];
            gt_d = (a_q != b_q) && sum[WordW];
          end
          default: acc_d = '0;
        endcase
      end
      ST_NEG_A: begin
        if (a_q[WordW-1]) begin
          a_d = sum[WordW-1:0];
        end
      end
      ST_NEG_B: begin
        if (b_q[WordW-1]) begin
          b_d = sum[WordW-1:0];
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        acc_d = sum[WordW] ? sum[WordW-1:0] : div_rem;
        a_d   = {a_q[WordW-2:0], sum[WordW]};
      end
      ST_NEG_Q: begin
        acc_d = sign_q ? sum[WordW-1:0] : a_q;
      end
      ST_MUL: begin
        cnt_d = cnt_q + 1'b1;
        if (b_q[0]) begin
          acc_d = sum[WordW-1:0];
        end
        a_d = {a_q[WordW-2:0], 1'b0};
        b_d = {1'b0, b_q[WordW-1:1]};
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_d       = acc_q;
          out_lt_d    = lt_q;
          out_eq_d    = eq_q;
          out_gt_d    = gt_q;
          out_err_d   = err_q;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    b_q       <= b_d;
    acc_q     <= acc_d;
    amt_q     <= amt_d;
    cnt_q     <= cnt_d;
    sign_q    <= sign_d;
    lt_q      <= lt_d;
    eq_q      <= eq_d;
    gt_q      <= gt_d;
    err_q     <= err_d;
    res_q     <= res_d;
    out_lt_q  <= out_lt_d;
    out_eq_q  <= out_eq_d;
    out_gt_q  <= out_gt_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_high_o = res_q[WordW-1:HalfW];
  assign result_low_o  = res_q[HalfW-1:0];
  assign less_o        = out_lt_q;
  assign equal_o       = out_eq_q;
  assign greater_o     = out_gt_q;
  assign error_o       = out_err_q;

endmodule
